[rtl/core/line_follow_state_machine_top_assert.svh]
// Assertion macros used by the line follower steering core.
`ifndef LINE_FOLLOW_STATE_MACHINE_TOP_ASSERT_SVH
`define LINE_FOLLOW_STATE_MACHINE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LFSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LFSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lfsm_pkg.sv]
// Shared types and constants of the line follower steering block.
package lfsm_pkg;

    // Configuration port geometry.
    localparam int unsigned LFSM_ADDR_W = 3;
    localparam int unsigned LFSM_DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_NORMAL_DWELL = 1'b0;
    localparam logic REG_STOP_DWELL   = 1'b1;

    localparam logic [7:0] NORMAL_DWELL_RESET = 8'd50;
    localparam logic [7:0] STOP_DWELL_RESET   = 8'd250;

    // Position class of one sensor reading.
    typedef enum logic [2:0] {
        CLS_CENTER       = 3'd0,
        CLS_LEFT         = 3'd1,
        CLS_SLIGHT_LEFT  = 3'd2,
        CLS_RIGHT        = 3'd3,
        CLS_SLIGHT_RIGHT = 3'd4,
        CLS_LOST         = 3'd5
    } lfsm_class_t;

    // Dwell settings handed from the register file to the steering core.
    typedef struct packed {
        logic [7:0] normal_dwell;
        logic [7:0] stop_dwell;
    } lfsm_cfg_t;

endpackage

[rtl/core/lfsm_if.sv]
// Valid/ready channel interfaces for sensor requests and steering results.
interface lfsm_sensor_if;
    logic       valid;
    logic       ready;
    logic [7:0] sensor_byte;

    modport source (output valid, output sensor_byte, input ready);
    modport sink (input valid, input sensor_byte, output ready);
endinterface

interface lfsm_result_if;
    logic       valid;
    logic       ready;
    logic [4:0] motor_command;
    logic [7:0] dwell_ms;
    logic [2:0] position_class;
    logic       stopped;

    modport source (output valid, output motor_command, output dwell_ms,
                    output position_class, output stopped, input ready);
    modport sink (input valid, input motor_command, input dwell_ms,
                  input position_class, input stopped, output ready);
endinterface

[rtl/core/line_follow_state_machine_top.sv]
// Top level of the line follower steering block.
//
// The block takes one request per sensor reading on the sensor channel: an
// eight-bit reflectance byte, one bit per sensor. Each request produces exactly
// one item on the result channel carrying the new steering state's motor
// command, how many milliseconds to hold it, the position class that was used
// and a flag that is set once the machine has reached its absorbing stop state.
// Both channels use a valid/ready handshake; an item moves when both are high.
// A request is registered on acceptance, then classified and stepped through
// the Moore machine on its way into the result register, which takes it when
// empty or when its item is being taken. One request is taken every cycle; the
// input register and the result register are the only stages, so throughput
// is one item per clock while the receiver keeps ready high. When the receiver
// stalls, the result is held and one further request may be parked in the
// input register; after that the sensor channel deasserts ready. Reset (rst_n
// low, asynchronous) empties both stages, returns the machine to the centre
// state and loads the dwell registers with 50 ms and 250 ms. The APB port
// holds normal_dwell at byte address 0 and stop_dwell at 4; the user must
// write it only while no request is in flight, as the block itself does not
// enforce this.
module line_follow_state_machine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    lfsm_sensor_if.sink                      sensor,
    lfsm_result_if.source                    result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lfsm_pkg::LFSM_ADDR_W-1:0] paddr,
    input  logic [lfsm_pkg::LFSM_DATA_W-1:0] pwdata,
    output logic [lfsm_pkg::LFSM_DATA_W-1:0] prdata,
    output logic                             pready
);
    import lfsm_pkg::*;

    // Dwell settings; the user must keep them stable whenever a request is being processed, unchecked by the block.
    lfsm_cfg_t cfg;

    lfsm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The steering core holds the input register, the state register and the
    // result register, and drives both handshakes.
    lfsm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sensor (sensor),
        .result (result)
    );

endmodule

[rtl/core/lfsm_apb_regs.sv]
// APB register file holding the two dwell settings.
module lfsm_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lfsm_pkg::LFSM_ADDR_W-1:0] paddr,
    input  logic [lfsm_pkg::LFSM_DATA_W-1:0] pwdata,
    output logic [lfsm_pkg::LFSM_DATA_W-1:0] prdata,
    output logic                            pready,
    output lfsm_pkg::lfsm_cfg_t             cfg
);
    import lfsm_pkg::*;

    logic [7:0] normal_dwell_reg;
    logic [7:0] stop_dwell_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_dwell_reg <= NORMAL_DWELL_RESET;
            stop_dwell_reg   <= STOP_DWELL_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_NORMAL_DWELL: normal_dwell_reg <= pwdata[7:0];
                REG_STOP_DWELL:   stop_dwell_reg   <= pwdata[7:0];
                default:          normal_dwell_reg <= normal_dwell_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_NORMAL_DWELL: prdata = {{(LFSM_DATA_W-8){1'b0}}, normal_dwell_reg};
            REG_STOP_DWELL:   prdata = {{(LFSM_DATA_W-8){1'b0}}, stop_dwell_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.normal_dwell = normal_dwell_reg;
    assign cfg.stop_dwell   = stop_dwell_reg;

endmodule

[rtl/core/lfsm_classify.sv]
// Sorts one sensor byte into a position class, first matching test wins.
module lfsm_classify (
    input  logic [7:0]            sensor_byte,
    output lfsm_pkg::lfsm_class_t position_class
);
    import lfsm_pkg::*;

    logic is_center_pattern;

    // Patterns that read as centred; all but 8'hFF fall inside other ranges.
    assign is_center_pattern = (sensor_byte == 8'h18) || (sensor_byte == 8'hFF) ||
                               (sensor_byte == 8'h3C) || (sensor_byte == 8'h7E);

    always_comb
    begin
        if (is_center_pattern)
            position_class = CLS_CENTER;
        else if (sensor_byte >= 8'h08 && sensor_byte <= 8'h0C)
            position_class = CLS_SLIGHT_LEFT;
        else if (sensor_byte >= 8'h01 && sensor_byte <= 8'h0F)
            position_class = CLS_LEFT;
        else if (sensor_byte >= 8'h10 && sensor_byte <= 8'h7F)
            position_class = CLS_SLIGHT_RIGHT;
        else if (sensor_byte >= 8'h80 && sensor_byte <= 8'hF0)
            position_class = CLS_RIGHT;
        else if (sensor_byte == 8'h00)
            position_class = CLS_LOST;
        else
            position_class = CLS_CENTER;
    end

endmodule

[rtl/core/lfsm_core.sv]
// Steering core: input register, Moore state update and result register.
module lfsm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  lfsm_pkg::lfsm_cfg_t cfg,
    lfsm_sensor_if.sink         sensor,
    lfsm_result_if.source       result
);
    import lfsm_pkg::*;

    typedef enum logic [3:0] {
        ST_CENTER       = 4'd0,
        ST_SLIGHT_LEFT  = 4'd1,
        ST_LEFT         = 4'd2,
        ST_SLIGHT_RIGHT = 4'd3,
        ST_RIGHT        = 4'd4,
        ST_BUF_CENTER   = 4'd5,
        ST_BUF_CENTER2  = 4'd6,
        ST_OFF_CENTER   = 4'd7,
        ST_OFF_LEFT1    = 4'd8,
        ST_OFF_LEFT2    = 4'd9,
        ST_OFF_LEFT3    = 4'd10,
        ST_OFF_RIGHT1   = 4'd11,
        ST_OFF_RIGHT2   = 4'd12,
        ST_OFF_RIGHT3   = 4'd13,
        ST_STOP         = 4'd14
    } state_t;

    localparam logic [4:0] CMD_STOP     = 5'h00;
    localparam logic [4:0] CMD_RIGHT    = 5'h01;
    localparam logic [4:0] CMD_LEFT     = 5'h02;
    localparam logic [4:0] CMD_STRAIGHT = 5'h03;
    localparam logic [4:0] CMD_OFF_RGT  = 5'h09;
    localparam logic [4:0] CMD_OFF_LFT  = 5'h0A;
    localparam logic [4:0] CMD_SLT_LEFT = 5'h0B;
    localparam logic [4:0] CMD_SLT_RGT  = 5'h13;

    function automatic logic [4:0] cmd_of(input state_t st);
        logic [4:0] cmd;
        case (st)
            ST_SLIGHT_LEFT:  cmd = CMD_SLT_LEFT;
            ST_LEFT:         cmd = CMD_LEFT;
            ST_SLIGHT_RIGHT: cmd = CMD_SLT_RGT;
            ST_RIGHT:        cmd = CMD_RIGHT;
            ST_OFF_LEFT1,
            ST_OFF_LEFT2,
            ST_OFF_LEFT3:    cmd = CMD_OFF_LFT;
            ST_OFF_RIGHT1,
            ST_OFF_RIGHT2,
            ST_OFF_RIGHT3:   cmd = CMD_OFF_RGT;
            ST_STOP:         cmd = CMD_STOP;
            default:         cmd = CMD_STRAIGHT;
        endcase
        return cmd;
    endfunction

    function automatic state_t lost_next(input state_t st);
        state_t nx;
        case (st)
            ST_CENTER:       nx = ST_BUF_CENTER;
            ST_SLIGHT_LEFT,
            ST_LEFT:         nx = ST_OFF_LEFT1;
            ST_SLIGHT_RIGHT,
            ST_RIGHT:        nx = ST_OFF_RIGHT1;
            ST_BUF_CENTER:   nx = ST_BUF_CENTER2;
            ST_BUF_CENTER2:  nx = ST_OFF_CENTER;
            ST_OFF_CENTER:   nx = ST_STOP;
            ST_OFF_LEFT1:    nx = ST_OFF_LEFT2;
            ST_OFF_LEFT2:    nx = ST_OFF_LEFT3;
            ST_OFF_LEFT3:    nx = ST_BUF_CENTER2;
            ST_OFF_RIGHT1:   nx = ST_OFF_RIGHT2;
            ST_OFF_RIGHT2:   nx = ST_OFF_RIGHT3;
            ST_OFF_RIGHT3:   nx = ST_BUF_CENTER2;
            ST_STOP:         nx = ST_STOP;
            default:         nx = ST_BUF_CENTER;
        endcase
        return nx;
    endfunction

    // Input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    // Result stage
    logic        out_valid_reg;
    logic [4:0]  cmd_reg;
    logic [7:0]  dwell_reg;
    logic [2:0]  class_reg;
    logic        stopped_reg;

    state_t      state_reg;
    state_t      state_next;
    lfsm_class_t cls;

    lfsm_classify u_classify (
        .sensor_byte    (in_byte_reg),
        .position_class (cls)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sensor.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (state_reg == ST_STOP)
            state_next = ST_STOP;
        else
        begin
            case (cls)
                CLS_CENTER:       state_next = ST_CENTER;
                CLS_LEFT:         state_next = ST_LEFT;
                CLS_SLIGHT_LEFT:  state_next = ST_SLIGHT_LEFT;
                CLS_RIGHT:        state_next = ST_RIGHT;
                CLS_SLIGHT_RIGHT: state_next = ST_SLIGHT_RIGHT;
                CLS_LOST:         state_next = lost_next(state_reg);
                default:          state_next = ST_CENTER;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_CENTER;
        end
        else
        begin
            if (sensor.valid && sensor.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sensor.valid && sensor.ready)
            in_byte_reg <= sensor.sensor_byte;
        if (advance)
        begin
            cmd_reg     <= cmd_of(state_next);
            dwell_reg   <= (state_next == ST_STOP) ? cfg.stop_dwell : cfg.normal_dwell;
            class_reg   <= cls;
            stopped_reg <= (state_next == ST_STOP);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.motor_command  = cmd_reg;
    assign result.dwell_ms       = dwell_reg;
    assign result.position_class = class_reg;
    assign result.stopped        = stopped_reg;

`include "line_follow_state_machine_top_assert.svh"

    `LFSM_ASSERT_NEXT(a_stop_absorbs, state_reg == ST_STOP, state_reg == ST_STOP,
        "stop state was left")
    `LFSM_ASSERT_NOW(a_stopped_matches_state, out_valid_reg && stopped_reg,
        state_reg == ST_STOP, "stopped result while state is not stop")
    `LFSM_ASSERT_NEXT(a_held_request_kept, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg), "held sensor request was lost")
    `LFSM_ASSERT_NOW(a_empty_stage_ready, !in_valid_reg, sensor.ready,
        "empty input stage refused a request")

endmodule
